[hdl/pmsb_pkg.sv]
// shared types and constants for the priority-masked sprite blitter
// used by priority_masked_sprite_blit_core and its testbench; no dependencies
`default_nettype none

package pmsb_pkg;

  localparam int SCREEN_WIDTH  = 160;
  localparam int SCREEN_HEIGHT = 168;
  localparam int RAM_DEPTH     = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W        = $clog2(RAM_DEPTH);

  // priority nibbles
  localparam logic [3:0] PRI_CONTROL_LIMIT = 4'd3;
  localparam logic [3:0] PRI_NO_FLOOR      = 4'd4;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_READ = 2'd1,
    CMD_DRAW = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    REG_SPRITE_PRIORITY    = 1'b0,
    REG_TRANSPARENT_COLOUR = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_WALK,
    ST_HOLD
  } state_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] value;
    logic       last_pixel;
  } pmsb_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       drawn;
    logic       cel_hidden;
  } pmsb_out_t;

endpackage

`default_nettype wire

[hdl/pmsb_ram.sv]
// generic single-port synchronous ram, registered read, no reset
// standalone; instanced by priority_masked_sprite_blit_core
`default_nettype none

module pmsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

[hdl/priority_masked_sprite_blit_core.sv]
// priority-masked sprite blitter: screen ram, column walk sequencer, result register
// depends on pmsb_pkg and pmsb_ram
//
// usage:
//   requests enter on in_valid_i / in_data_i and are taken when in_stall_o is low.
//   each request gives exactly one result on out_valid_o / out_data_o, taken when
//   out_stall_i is low. a result register sits on the output, so a new request is
//   taken while the previous result is still waiting.
//   sprite priority and transparent colour are written through cfg_we_i, cfg_idx_i
//   and cfg_data_i while no request is in flight.
// sequence:
//   load, unused command or off-screen access: finished in the idle state.
//   read, and draw over a normal priority band: ram read, then decide
//   and write back in the same cycle.
//   draw over a control line: the ram read, then a walk down the column, at most
//   SCREEN_HEIGHT - 1 - row rows, one ram read per row, then decide and write back.
//   the single ram port allows one access per cycle.
// reset: control state and the cel tracking clear at once; the screen ram holds
//   no defined contents until loaded. no clearing pass is run.
// stall: a finished result that cannot enter the output register is parked and
//   no new request is taken until it moves on.
`default_nettype none

module priority_masked_sprite_blit_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire pmsb_pkg::pmsb_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output pmsb_pkg::pmsb_out_t      out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [0:0]          cfg_idx_i,
  input  wire logic [3:0]          cfg_data_i
);

  import pmsb_pkg::*;

  state_e            state_q, state_d;
  pmsb_in_t          item_q;
  pmsb_in_t          cur_item;
  logic [ADDR_W-1:0] addr_q, addr_d, addr_in;
  logic [ADDR_W-1:0] base_q;
  logic [7:0]        row_q, row_d;
  logic [7:0]        cur_q;
  logic [7:0]        cur_byte;
  logic [3:0]        spr_q, transp_q;
  logic              any_drawn_q, any_drawn_d;
  logic              out_valid_q;
  pmsb_out_t         out_q, pend_q, res;
  logic              out_free;
  logic              onscreen_in;
  logic              fin, walk_go, is_ctrl, at_bottom;
  logic [3:0]        epr;
  logic              decide;
  logic [3:0]        colour;
  logic [7:0]        nb;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata, ram_rdata;

  pmsb_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign cur_item    = (state_q == ST_IDLE) ? in_data_i : item_q;
  assign onscreen_in = (32'(in_data_i.col) < SCREEN_WIDTH) &&
                       (32'(in_data_i.row) < SCREEN_HEIGHT);
  assign addr_in     = ADDR_W'(in_data_i.row) * ADDR_W'(SCREEN_WIDTH) +
                       ADDR_W'(in_data_i.col);

  assign cur_byte  = (state_q == ST_LOOKUP) ? ram_rdata : cur_q;
  assign is_ctrl   = cur_byte[7:4] < PRI_CONTROL_LIMIT;
  assign at_bottom = (32'(row_q) == SCREEN_HEIGHT - 1);
  assign colour    = cur_item.value[3:0];
  assign nb        = {(is_ctrl ? cur_byte[7:4] : spr_q), colour};

  // datapath and ram control
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = addr_q;
    ram_wdata = nb;
    fin       = 1'b0;
    walk_go   = 1'b0;
    decide    = 1'b0;
    epr       = PRI_NO_FLOOR;
    res       = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ram_addr = addr_in;
          case (in_data_i.cmd)
            CMD_LOAD: begin
              ram_we    = onscreen_in;
              ram_wdata = in_data_i.value;
              fin       = 1'b1;
            end
            CMD_READ, CMD_DRAW: begin
              fin = !onscreen_in;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        if (item_q.cmd == CMD_DRAW) begin
          if (!is_ctrl) begin
            epr    = cur_byte[7:4];
            decide = 1'b1;
          end else if (at_bottom) begin
            decide = 1'b1;
          end else begin
            walk_go = 1'b1;
          end
        end else begin
          res.read_data = ram_rdata;
          fin           = 1'b1;
        end
      end
      ST_WALK: begin
        if (ram_rdata[7:4] >= PRI_CONTROL_LIMIT) begin
          epr    = ram_rdata[7:4];
          decide = 1'b1;
        end else if (at_bottom) begin
          decide = 1'b1;
        end else begin
          walk_go = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (walk_go) begin
      ram_addr = addr_q + ADDR_W'(SCREEN_WIDTH);
    end

    if (decide) begin
      // write back goes to the pixel itself, not the walked row
      ram_addr = base_q;
      fin      = 1'b1;
      if (colour != transp_q && spr_q >= epr) begin
        ram_we        = 1'b1;
        res.read_data = nb;
        res.drawn     = 1'b1;
      end else begin
        res.read_data = cur_byte;
      end
    end

    res.cel_hidden = fin && (cur_item.cmd == CMD_DRAW) && cur_item.last_pixel &&
                     !(any_drawn_q || res.drawn);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (fin) begin
            state_d = out_free ? ST_IDLE : ST_HOLD;
          end else begin
            state_d = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP, ST_WALK: begin
        if (fin) begin
          state_d = out_free ? ST_IDLE : ST_HOLD;
        end else if (walk_go) begin
          state_d = ST_WALK;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // walk position and cel tracking
  always_comb begin
    addr_d      = addr_q;
    row_d       = row_q;
    any_drawn_d = any_drawn_q;
    if (state_q == ST_IDLE && in_valid_i) begin
      addr_d = addr_in;
      row_d  = in_data_i.row;
    end else if (walk_go) begin
      addr_d = addr_q + ADDR_W'(SCREEN_WIDTH);
      row_d  = row_q + 8'd1;
    end
    if (fin && cur_item.cmd == CMD_DRAW) begin
      any_drawn_d = cur_item.last_pixel ? 1'b0 : (any_drawn_q || res.drawn);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      any_drawn_q <= 1'b0;
      out_valid_q <= 1'b0;
      spr_q       <= '0;
      transp_q    <= '0;
    end else begin
      state_q     <= state_d;
      any_drawn_q <= any_drawn_d;
      if ((fin || state_q == ST_HOLD) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SPRITE_PRIORITY:    spr_q    <= cfg_data_i;
          REG_TRANSPARENT_COLOUR: transp_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    row_q  <= row_d;
    if (state_q == ST_IDLE && in_valid_i) begin
      item_q <= in_data_i;
      base_q <= addr_in;
    end
    if (state_q == ST_LOOKUP) begin
      cur_q <= ram_rdata;
    end
    if (fin && !out_free) begin
      pend_q <= res;
    end
    if ((fin || state_q == ST_HOLD) && out_free) begin
      out_q <= (state_q == ST_HOLD) ? pend_q : res;
    end
  end

  // the column walk stays on screen
  a_walk_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (32'(row_q) < SCREEN_HEIGHT))
    else $error("column walk left the screen");

  // a drawn pixel is a draw request that writes the ram
  a_drawn_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && res.drawn) |-> (ram_we && cur_item.cmd == CMD_DRAW))
    else $error("drawn reported without a screen write");

  // the last pixel of a cel clears the tracking
  a_cel_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && cur_item.cmd == CMD_DRAW && cur_item.last_pixel) |=> !any_drawn_q)
    else $error("cel tracking not cleared after last pixel");

  // a parked result only exists behind a full, stalled output register
  a_hold_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD) |-> out_valid_q)
    else $error("result parked while output register empty");

  // no ram write, result or walk step happens while a result is parked
  a_hold_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD) |-> (!ram_we && !fin && !walk_go))
    else $error("activity while a result is parked");

endmodule

`default_nettype wire

[tb/tb_priority_masked_sprite_blit_core.sv]
// testbench for priority_masked_sprite_blit_core: queued requests, random idling on both sides,
// a screen mirror that predicts every result, register settings changed between phases
// depends on pmsb_pkg and priority_masked_sprite_blit_core
`timescale 1ns / 100ps

module tb_priority_masked_sprite_blit_core;
  import pmsb_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  pmsb_in_t   in_req = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  pmsb_out_t  out_data;
  logic       cfg_we = 1'b0;
  reg_e       cfg_idx = REG_SPRITE_PRIORITY;
  logic [3:0] cfg_data = 4'd0;

  priority_masked_sprite_blit_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // screen mirror, cel tracking and register copies
  logic [7:0] screen_mirror [RAM_DEPTH];
  bit         cel_any_drawn = 1'b0;
  logic [3:0] spr_level = 4'd0;
  logic [3:0] clear_colour = 4'd0;

  // what has been loaded so far, and which loads left a control line
  bit loaded_map [SCREEN_WIDTH][SCREEN_HEIGHT];
  bit ctrl_map   [SCREEN_WIDTH][SCREEN_HEIGHT];
  int lane_cols  [6];

  pmsb_in_t  request_q [$];
  pmsb_out_t blit_result_q [$];
  pmsb_out_t want;

  int  send_gap = 0;
  int  hold_cycles = 0;
  bit  calm_send = 1'b0;
  bit  calm_recv = 1'b0;
  int  live_items = 0;
  int  n_faults = 0;
  int  n_requests = 0;
  int  n_results = 0;
  int  n_draws = 0;
  int  n_painted = 0;
  int  n_walks = 0;
  int  n_floorless = 0;
  int  n_cels = 0;
  int  n_hidden = 0;
  int  n_settings = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic pmsb_out_t blit_step(pmsb_in_t rq);
    pmsb_out_t  res;
    int         addr;
    int         y;
    bit         on_screen;
    bit         found;
    logic [3:0] cur_pri;
    logic [3:0] eff_pri;
    res = '0;
    on_screen = (int'(rq.col) < SCREEN_WIDTH) && (int'(rq.row) < SCREEN_HEIGHT);
    addr = int'(rq.row) * SCREEN_WIDTH + int'(rq.col);
    case (rq.cmd)
      CMD_LOAD: begin
        if (on_screen) screen_mirror[addr] = rq.value;
      end
      CMD_READ: begin
        if (on_screen) res.read_data = screen_mirror[addr];
      end
      CMD_DRAW: begin
        n_draws++;
        if (on_screen) begin
          cur_pri = screen_mirror[addr][7:4];
          eff_pri = cur_pri;
          if (cur_pri < PRI_CONTROL_LIMIT) begin
            // control line: take the first real band further down the column
            n_walks++;
            found = 1'b0;
            eff_pri = PRI_NO_FLOOR;
            for (y = int'(rq.row); y < SCREEN_HEIGHT && !found; y++) begin
              if (screen_mirror[y * SCREEN_WIDTH + int'(rq.col)][7:4] >= PRI_CONTROL_LIMIT) begin
                eff_pri = screen_mirror[y * SCREEN_WIDTH + int'(rq.col)][7:4];
                found = 1'b1;
              end
            end
            if (!found) n_floorless++;
          end
          if (rq.value[3:0] != clear_colour && spr_level >= eff_pri) begin
            screen_mirror[addr] = {(cur_pri < PRI_CONTROL_LIMIT) ? cur_pri : spr_level,
                                   rq.value[3:0]};
            res.drawn = 1'b1;
            cel_any_drawn = 1'b1;
            n_painted++;
          end
          res.read_data = screen_mirror[addr];
        end
        if (rq.last_pixel) begin
          res.cel_hidden = !cel_any_drawn;
          cel_any_drawn = 1'b0;
          n_cels++;
          if (res.cel_hidden) n_hidden++;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // a draw may only touch loaded entries, down to the first real band or the bottom row
  function automatic bit walk_covered(int col, int row);
    bit ok;
    bit done;
    int y;
    ok = 1'b1;
    done = 1'b0;
    for (y = row; y < SCREEN_HEIGHT && !done; y++) begin
      if (!loaded_map[col][y]) begin
        ok = 1'b0;
        done = 1'b1;
      end else if (!ctrl_map[col][y]) begin
        done = 1'b1;
      end
    end
    return ok;
  endfunction

  task automatic send(cmd_e cmd, int col, int row, logic [7:0] value, bit last);
    pmsb_in_t rq;
    bit       on_screen;
    on_screen = col < SCREEN_WIDTH && row < SCREEN_HEIGHT;
    // an access that would reach a never-loaded entry loads it instead
    if (on_screen && ((cmd == CMD_READ && !loaded_map[col][row]) ||
                      (cmd == CMD_DRAW && !walk_covered(col, row)))) begin
      cmd = CMD_LOAD;
    end
    if (cmd == CMD_LOAD && on_screen) begin
      loaded_map[col][row] = 1'b1;
      ctrl_map[col][row] = value[7:4] < PRI_CONTROL_LIMIT;
    end
    if (cmd != CMD_NONE && !(cmd == CMD_LOAD && !on_screen)) live_items++;
    rq.cmd = cmd;
    rq.col = col[7:0];
    rq.row = row[7:0];
    rq.value = value;
    rq.last_pixel = last;
    request_q.push_back(rq);
  endtask

  task automatic settle();
    while (request_q.size() != 0 || in_valid || blit_result_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_cfg(logic [3:0] level, logic [3:0] colour);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_SPRITE_PRIORITY;
    cfg_data <= level;
    @(posedge clk);
    cfg_idx  <= REG_TRANSPARENT_COLOUR;
    cfg_data <= colour;
    @(posedge clk);
    cfg_we   <= 1'b0;
    spr_level = level;
    clear_colour = colour;
    n_settings++;
  endtask

  // request side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        blit_result_q.push_back(blit_step(in_req));
        n_requests++;
        send_gap = calm_send ? 0 : int'($urandom_range(0, 17));
        if ($urandom_range(0, 39) == 0) calm_send = !calm_send;
      end
      if (in_valid && in_stall) begin
        // payload held while stalled
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (request_q.size() != 0) begin
        in_req   <= request_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (blit_result_q.size() == 0) begin
          $display("%0t ns: result %0d with no request waiting, got %h", $time, n_results,
                   out_data);
          n_faults++;
        end else begin
          want = blit_result_q.pop_front();
          if (out_data.read_data !== want.read_data) begin
            $display("%0t ns: result %0d read_data expected %02h actual %02h", $time,
                     n_results, want.read_data, out_data.read_data);
            n_faults++;
          end
          if (out_data.drawn !== want.drawn) begin
            $display("%0t ns: result %0d drawn expected %0b actual %0b", $time,
                     n_results, want.drawn, out_data.drawn);
            n_faults++;
          end
          if (out_data.cel_hidden !== want.cel_hidden) begin
            $display("%0t ns: result %0d cel_hidden expected %0b actual %0b", $time,
                     n_results, want.cel_hidden, out_data.cel_hidden);
            n_faults++;
          end
        end
        hold_cycles = calm_recv ? 0 : int'($urandom_range(0, 17));
        if ($urandom_range(0, 39) == 0) calm_recv = !calm_recv;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int         c;
    int         c2;
    int         r0;
    int         k;
    int         n;
    int         i;
    int         rr;
    int         pick;
    int         phase_no;
    int         next_phase;
    logic [3:0] pri;
    logic [3:0] colour;

    lane_cols[0] = 0;
    lane_cols[1] = SCREEN_WIDTH - 1;
    for (i = 2; i < 6; i++) lane_cols[i] = int'($urandom_range(1, SCREEN_WIDTH - 2));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_cfg(4'd4, 4'd5);

    // walk to the bottom with no band below, then a transparent last pixel
    send(CMD_LOAD, 159, 167, 8'h10, 1'b0);
    send(CMD_LOAD, 159, 166, 8'h25, 1'b1);
    send(CMD_DRAW, 159, 166, 8'hf3, 1'b0);
    send(CMD_DRAW, 159, 167, 8'h05, 1'b1);
    // short walk onto a band, a higher band that hides, a cel with nothing drawn
    send(CMD_LOAD, 0, 0, 8'hff, 1'b0);
    send(CMD_LOAD, 0, 1, 8'h00, 1'b0);
    send(CMD_LOAD, 0, 2, 8'h37, 1'b0);
    send(CMD_READ, 0, 0, 8'h00, 1'b1);
    send(CMD_DRAW, 0, 1, 8'h0a, 1'b0);
    send(CMD_DRAW, 0, 0, 8'h01, 1'b1);
    send(CMD_DRAW, 0, 0, 8'h01, 1'b1);
    // off-screen accesses and the unused command, between on-screen draws, a load and a read
    send(CMD_LOAD, 255, 255, 8'hff, 1'b1);
    send(CMD_READ, 255, 255, 8'hff, 1'b1);
    send(CMD_DRAW, 160, 0, 8'h0f, 1'b1);
    send(CMD_DRAW, 0, 2, 8'h02, 1'b0);
    send(CMD_NONE, 255, 255, 8'hff, 1'b1);
    send(CMD_LOAD, 0, 3, 8'h00, 1'b1);
    send(CMD_DRAW, 200, 200, 8'h00, 1'b1);
    send(CMD_READ, 0, 2, 8'h00, 1'b0);
    send(CMD_DRAW, 0, 1, 8'h0a, 1'b1);

    phase_no = 0;
    next_phase = 0;
    while (live_items < 1100) begin
      if (live_items >= next_phase) begin
        // every request answered before the registers move
        settle();
        case (phase_no)
          0:       write_cfg(4'd0, 4'd0);
          1:       write_cfg(4'd15, 4'd15);
          2:       write_cfg(4'd15, 4'd0);
          3:       write_cfg(4'd0, 4'd15);
          default: write_cfg(4'($urandom_range(3, 15)), 4'($urandom));
        endcase
        phase_no++;
        next_phase = live_items + 120;
      end
      pick = int'($urandom_range(0, 9));
      if (pick < 6) begin
        // column segment of control lines, usually closed by a band, then a cel over it
        c  = lane_cols[$urandom_range(0, 5)];
        r0 = ($urandom_range(0, 3) == 0) ? int'($urandom_range(160, 167))
                                          : int'($urandom_range(0, 165));
        k  = int'($urandom_range(1, 6));
        for (i = 0; i < k && r0 + i < SCREEN_HEIGHT; i++) begin
          pri = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 2))
                                             : 4'($urandom_range(3, 15));
          send(CMD_LOAD, c, r0 + i, {pri, 4'($urandom)}, 1'($urandom));
        end
        if (r0 + k < SCREEN_HEIGHT && $urandom_range(0, 4) != 0) begin
          send(CMD_LOAD, c, r0 + k, {4'($urandom_range(3, 15)), 4'($urandom)}, 1'b0);
        end
        n = int'($urandom_range(1, 8));
        for (i = 0; i < n; i++) begin
          rr = r0 + int'($urandom_range(0, k));
          if (rr >= SCREEN_HEIGHT) rr = SCREEN_HEIGHT - 1;
          c2 = ($urandom_range(0, 4) == 0) ? lane_cols[$urandom_range(0, 5)] : c;
          colour = ($urandom_range(0, 3) == 0) ? clear_colour : 4'($urandom);
          if ($urandom_range(0, 5) == 0) send(CMD_READ, c2, rr, 8'($urandom), 1'($urandom));
          send(CMD_DRAW, c2, rr, {4'($urandom), colour}, i == n - 1);
        end
      end else if (pick < 8) begin
        // anything goes, off-screen included
        for (i = 0; i < 6; i++) begin
          c2 = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 255))
                                            : lane_cols[$urandom_range(0, 5)];
          rr = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 255))
                                            : int'($urandom_range(0, SCREEN_HEIGHT - 1));
          send(cmd_e'($urandom_range(0, 3)), c2, rr, 8'($urandom), 1'($urandom));
        end
      end else begin
        c2 = lane_cols[$urandom_range(0, 5)];
        rr = int'($urandom_range(0, SCREEN_HEIGHT - 4));
        for (i = 0; i < 4; i++) send(CMD_READ, c2, rr + i, 8'($urandom), 1'($urandom));
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("run covered %0d requests and %0d register settings; %0d draws, %0d painted,",
             n_requests, n_settings, n_draws, n_painted);
    $display("%0d over control lines (%0d with no band below), %0d cels, %0d fully hidden",
             n_walks, n_floorless, n_cels, n_hidden);
    if (n_faults == 0) begin
      $display("tb_priority_masked_sprite_blit_core: PASS");
    end else begin
      $display("tb_priority_masked_sprite_blit_core: FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timed out with %0d results still owed", blit_result_q.size());
    $display("tb_priority_masked_sprite_blit_core: FAIL");
    $finish;
  end

endmodule
